@@ src/brme_pkg.sv @@
// Shared constants, codes and types of the byte register machine execute block.
package brme_pkg;

  localparam int unsigned NUM_REGS_DEF    = 8;
  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned DATA_W          = 8;
  localparam int unsigned REG_IDX_W       = 3;
  localparam int unsigned SHAMT_W         = 3;
  localparam int unsigned COUNT_W         = 5;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned DIV_STEPS       = DATA_W;
  localparam logic [DATA_W-1:0] MAX_SHIFT = DATA_W'(DATA_W - 1);

  typedef enum logic [3:0] {
    OP_MOV,
    OP_OR,
    OP_XOR,
    OP_AND,
    OP_SHL,
    OP_SHR,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_CMP,
    OP_PUSH,
    OP_POP
  } op_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_SHIFT_IGNORED,
    ST_STACK_EMPTY,
    ST_STACK_FULL,
    ST_DIV_ZERO
  } status_e;

  typedef struct packed {
    op_e                  op;
    logic [REG_IDX_W-1:0] dest;
    logic [REG_IDX_W-1:0] src;
    logic                 use_imm;
    logic [DATA_W-1:0]    imm;
    logic                 shift_skip;
  } dec_t;

endpackage

@@ src/brme_in_if.sv @@
// Instruction channel carrying one decoded instruction per transaction.
interface brme_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] operation;
  logic [2:0] dest_reg;
  logic [2:0] src_reg;
  logic       use_immediate;
  logic [7:0] immediate;

  modport source (output valid, operation, dest_reg, src_reg, use_immediate, immediate,
                  input ready);
  modport sink (input valid, operation, dest_reg, src_reg, use_immediate, immediate,
                output ready);
endinterface

@@ src/brme_out_if.sv @@
// Result channel carrying one instruction outcome per transaction.
interface brme_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] written_value;
  logic       equal_flag;
  logic [4:0] stack_count;
  logic [2:0] status;

  modport source (output valid, written_value, equal_flag, stack_count, status,
                  input ready);
  modport sink (input valid, written_value, equal_flag, stack_count, status,
                output ready);
endinterface

@@ src/brme_front.sv @@
// Front end: accepts instructions and classifies them for the queue.
module brme_front (
  brme_in_if.sink          instr_i,
  input  logic             full_i,
  output logic             push_o,
  output brme_pkg::dec_t   entry_o
);
  import brme_pkg::*;

  logic is_shift;

  assign instr_i.ready = !full_i;
  assign push_o        = instr_i.valid && !full_i;

  assign is_shift = (op_e'(instr_i.operation) == OP_SHL) ||
                    (op_e'(instr_i.operation) == OP_SHR);

  always_comb begin
    entry_o.op         = op_e'(instr_i.operation);
    entry_o.dest       = instr_i.dest_reg;
    entry_o.src        = instr_i.src_reg;
    entry_o.use_imm    = instr_i.use_immediate;
    entry_o.imm        = instr_i.immediate;
    entry_o.shift_skip = is_shift && instr_i.use_immediate && (instr_i.immediate > MAX_SHIFT);
  end

endmodule

@@ src/brme_queue.sv @@
// Short queue of classified instructions between the front and back ends.
module brme_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  brme_pkg::dec_t entry_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output brme_pkg::dec_t entry_o
);
  import brme_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  dec_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ src/brme_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
module brme_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [brme_pkg::DATA_W-1:0] dividend_i,
  input  logic [brme_pkg::DATA_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [brme_pkg::DATA_W-1:0] quotient_o
);
  import brme_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS + 1);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] rem_q, quo_q, dsr_q;
  logic [DATA_W:0]   shifted, trial;

  assign shifted    = {rem_q, quo_q[DATA_W-1]};
  assign trial      = shifted - {1'b0, dsr_q};
  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DIV_STEPS);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q && (cnt_q != '0)) begin
      if (!trial[DATA_W]) begin
        rem_q <= trial[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ src/brme_back.sv @@
// Back end: register file, byte stack, execution sequencer and result register.
module brme_back #(
  parameter int unsigned NUM_REGS    = brme_pkg::NUM_REGS_DEF,
  parameter int unsigned STACK_DEPTH = brme_pkg::STACK_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  brme_pkg::dec_t              q_entry_i,
  output logic                        q_pop_o,
  output logic                        div_start_o,
  output logic [brme_pkg::DATA_W-1:0] div_dividend_o,
  output logic [brme_pkg::DATA_W-1:0] div_divisor_o,
  input  logic                        div_done_i,
  input  logic [brme_pkg::DATA_W-1:0] div_quotient_i,
  brme_out_if.source                  result_o
);
  import brme_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_REGS);
  localparam int unsigned SAW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SPW   = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_WB   = 2'd3;

  typedef struct packed {
    logic              wr;
    logic [DATA_W-1:0] val;
    logic              push;
    logic [DATA_W-1:0] push_val;
    logic              pop;
    logic              eq_wr;
    logic              eq_val;
    status_e           status;
  } res_t;

  logic [DATA_W-1:0] rf_mem [NUM_REGS];
  logic [DATA_W-1:0] st_mem [STACK_DEPTH];
  logic [NUM_REGS-1:0] rf_vld_q;

  logic [1:0]        state_q, state_d;
  dec_t              cur_q;
  res_t              res_q, ex, div_res;
  logic [SPW-1:0]    sp_q;
  logic              eq_q;
  logic              a_ok_q, b_ok_q;
  logic [DATA_W-1:0] a_data_q, b_data_q, st_data_q;
  logic [DATA_W-1:0] a_val, b_val, amt;
  logic [2*DATA_W-1:0] prod;
  logic [IDX_W-1:0]  rd_d_idx, rd_s_idx, wr_idx;
  logic [SAW-1:0]    st_rd_addr;
  logic              d_in, take, commit;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_val_q;
  logic              out_eq_q;
  logic [COUNT_W-1:0] out_cnt_q;
  status_e           out_st_q;

  assign take       = (state_q == S_IDLE) && q_valid_i;
  assign q_pop_o    = take;
  assign commit     = (state_q == S_WB) && (!out_valid_q || result_o.ready);
  assign rd_d_idx   = IDX_W'(q_entry_i.dest);
  assign rd_s_idx   = IDX_W'(q_entry_i.src);
  assign st_rd_addr = SAW'(sp_q - 1'b1);
  assign wr_idx     = IDX_W'(cur_q.dest);
  assign d_in       = (32'(cur_q.dest) < NUM_REGS);

  assign a_val = a_ok_q ? a_data_q : '0;
  assign b_val = b_ok_q ? b_data_q : '0;
  assign amt   = cur_q.use_imm ? cur_q.imm : b_val;
  assign prod  = a_val * b_val;

  assign div_start_o    = (state_q == S_EXEC) && (cur_q.op == OP_DIV) && (b_val != '0);
  assign div_dividend_o = a_val;
  assign div_divisor_o  = b_val;

  always_comb begin
    ex = '0;
    unique case (cur_q.op) inside
      OP_MOV: begin
        ex.wr  = 1'b1;
        ex.val = cur_q.use_imm ? cur_q.imm : b_val;
      end
      OP_OR: begin
        ex.wr  = 1'b1;
        ex.val = a_val | b_val;
      end
      OP_XOR: begin
        ex.wr  = 1'b1;
        ex.val = a_val ^ b_val;
      end
      OP_AND: begin
        ex.wr  = 1'b1;
        ex.val = a_val & b_val;
      end
      OP_SHL, OP_SHR: begin
        if (cur_q.shift_skip) begin
          ex.status = ST_SHIFT_IGNORED;
        end else begin
          ex.wr = 1'b1;
          if (amt > MAX_SHIFT) begin
            ex.val = '0;
          end else if (cur_q.op == OP_SHL) begin
            ex.val = a_val << amt[SHAMT_W-1:0];
          end else begin
            ex.val = a_val >> amt[SHAMT_W-1:0];
          end
        end
      end
      OP_ADD: begin
        ex.wr  = 1'b1;
        ex.val = a_val + b_val;
      end
      OP_SUB: begin
        ex.wr  = 1'b1;
        ex.val = a_val - b_val;
      end
      OP_MUL: begin
        ex.wr  = 1'b1;
        ex.val = prod[DATA_W-1:0];
      end
      OP_DIV: begin
        if (b_val == '0) begin
          ex.status = ST_DIV_ZERO;
        end
      end
      OP_CMP: begin
        ex.eq_wr  = 1'b1;
        ex.eq_val = (a_val == b_val);
      end
      OP_PUSH: begin
        if (32'(sp_q) >= STACK_DEPTH) begin
          ex.status = ST_STACK_FULL;
        end else begin
          ex.push     = 1'b1;
          ex.push_val = cur_q.use_imm ? cur_q.imm : a_val;
          ex.wr       = !cur_q.use_imm;
        end
      end
      OP_POP: begin
        if (sp_q == '0) begin
          ex.status = ST_STACK_EMPTY;
        end else begin
          ex.pop = 1'b1;
          ex.wr  = 1'b1;
          ex.val = st_data_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    div_res     = '0;
    div_res.wr  = 1'b1;
    div_res.val = div_quotient_i;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (q_valid_i) state_d = S_EXEC;
      S_EXEC: state_d = div_start_o ? S_DIV : S_WB;
      S_DIV:  if (div_done_i) state_d = S_WB;
      S_WB:   if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      eq_q        <= 1'b0;
      rf_vld_q    <= '0;
      a_ok_q      <= 1'b0;
      b_ok_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take) begin
        a_ok_q <= (32'(q_entry_i.dest) < NUM_REGS) && rf_vld_q[rd_d_idx];
        b_ok_q <= (32'(q_entry_i.src) < NUM_REGS) && rf_vld_q[rd_s_idx];
      end
      if (commit) begin
        out_valid_q <= 1'b1;
        if (res_q.wr && d_in) begin
          rf_vld_q[wr_idx] <= 1'b1;
        end
        if (res_q.push) begin
          sp_q <= sp_q + 1'b1;
        end else if (res_q.pop) begin
          sp_q <= sp_q - 1'b1;
        end
        if (res_q.eq_wr) begin
          eq_q <= res_q.eq_val;
        end
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q     <= q_entry_i;
      a_data_q  <= rf_mem[rd_d_idx];
      b_data_q  <= rf_mem[rd_s_idx];
      st_data_q <= st_mem[st_rd_addr];
    end
    if (state_q == S_EXEC) begin
      res_q <= ex;
    end else if ((state_q == S_DIV) && div_done_i) begin
      res_q <= div_res;
    end
    if (commit) begin
      out_val_q <= (res_q.wr && d_in) ? res_q.val : a_val;
      out_eq_q  <= res_q.eq_wr ? res_q.eq_val : eq_q;
      out_st_q  <= res_q.status;
      if (res_q.push) begin
        out_cnt_q <= COUNT_W'(sp_q + 1'b1);
      end else if (res_q.pop) begin
        out_cnt_q <= COUNT_W'(sp_q - 1'b1);
      end else begin
        out_cnt_q <= COUNT_W'(sp_q);
      end
      if (res_q.wr && d_in) begin
        rf_mem[wr_idx] <= res_q.val;
      end
      if (res_q.push) begin
        st_mem[SAW'(sp_q)] <= res_q.push_val;
      end
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.written_value = out_val_q;
  assign result_o.equal_flag    = out_eq_q;
  assign result_o.stack_count   = out_cnt_q;
  assign result_o.status        = out_st_q;

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && res_q.push |-> 32'(sp_q) < STACK_DEPTH)
    else $error("Push committed onto a full stack.");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && res_q.pop |=> sp_q == SPW'($past(sp_q) - 1'b1))
    else $error("Pop did not lower the stack pointer by one.");

  a_result_after_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_WB)
    else $error("Result appeared without a write-back.");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cur_q.op == OP_DIV)
    else $error("Divider wait entered for another operation.");
`endif

endmodule

@@ src/byte_register_machine_execute.sv @@
// An instruction passes through operand read, execute and write-back in the back end, and a
// divide also waits on the divider, which produces one quotient bit per cycle; the next
// instruction reads its operands only after the previous write-back. A two-entry queue lets
// instructions be accepted while one executes, and the result register holds a finished
// result until it is taken, although write-back waits while it is still occupied.
module byte_register_machine_execute #(
  parameter int unsigned NUM_REGS    = brme_pkg::NUM_REGS_DEF,
  parameter int unsigned STACK_DEPTH = brme_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  brme_in_if.sink    instr_i,
  brme_out_if.source result_o
);
  import brme_pkg::*;

  logic              push, full, pop, q_valid;
  dec_t              push_entry, q_entry;
  logic              div_start, div_done;
  logic [DATA_W-1:0] div_dividend, div_divisor, div_quotient;

  brme_front u_front (
    .instr_i (instr_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  brme_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  brme_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  brme_back #(
    .NUM_REGS    (NUM_REGS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_entry_i      (q_entry),
    .q_pop_o        (pop),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quotient_i (div_quotient),
    .result_o       (result_o)
  );

endmodule

@@ dv/brme_result_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts every instruction outcome and compares it with the result channel.
module brme_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  brme_in_if   instr_mon,
  brme_out_if  result_mon,
  output int   fail_count_o,
  output int   pending_o
);
  import brme_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       equal;
    logic [4:0] depth;
    status_e    status;
  } outcome_t;

  logic [7:0] regs [NUM_REGS_DEF];
  logic [7:0] byte_stack [STACK_DEPTH_DEF];
  logic [4:0] depth;
  logic       equal_bit;
  outcome_t   expected_outcomes [$];
  int         fail_count;

  function automatic outcome_t execute_instr(input logic [3:0] opcode, input logic [2:0] d,
                                             input logic [2:0] s, input logic use_imm,
                                             input logic [7:0] imm);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] count;
    status_e    st;
    outcome_t   o;
    a = regs[d];
    b = regs[s];
    st = ST_OK;
    case (opcode) inside
      OP_MOV: regs[d] = use_imm ? imm : b;
      OP_OR:  regs[d] = a | b;
      OP_XOR: regs[d] = a ^ b;
      OP_AND: regs[d] = a & b;
      OP_SHL, OP_SHR: begin
        count = use_imm ? imm : b;
        if (use_imm && imm > MAX_SHIFT) begin
          st = ST_SHIFT_IGNORED;
        end else if (count > MAX_SHIFT) begin
          regs[d] = 8'h00;
        end else if (opcode == OP_SHL) begin
          regs[d] = a << count[2:0];
        end else begin
          regs[d] = a >> count[2:0];
        end
      end
      OP_ADD: regs[d] = a + b;
      OP_SUB: regs[d] = a - b;
      OP_MUL: regs[d] = a * b;
      OP_DIV: begin
        if (b == 8'h00) begin
          st = ST_DIV_ZERO;
        end else begin
          regs[d] = a / b;
        end
      end
      OP_CMP: equal_bit = (a == b);
      OP_PUSH: begin
        if (depth >= 5'(STACK_DEPTH_DEF)) begin
          st = ST_STACK_FULL;
        end else begin
          byte_stack[depth[3:0]] = use_imm ? imm : a;
          if (!use_imm) begin
            regs[d] = 8'h00;
          end
          depth = depth + 5'd1;
        end
      end
      OP_POP: begin
        if (depth == 5'd0) begin
          st = ST_STACK_EMPTY;
        end else begin
          depth = depth - 5'd1;
          regs[d] = byte_stack[depth[3:0]];
        end
      end
      default: ;
    endcase
    o.value = regs[d];
    o.equal = equal_bit;
    o.depth = depth;
    o.status = st;
    return o;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t exp_o;
    outcome_t next_o;
    if (!rst_ni) begin
      foreach (regs[i]) regs[i] = 8'h00;
      foreach (byte_stack[i]) byte_stack[i] = 8'h00;
      depth = 5'd0;
      equal_bit = 1'b0;
      expected_outcomes.delete();
      fail_count = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        if (expected_outcomes.size() == 0) begin
          fail_count++;
          $display("%0t: result transaction with nothing expected, expected none, actual %0h",
                   $time, {result_mon.written_value, result_mon.equal_flag,
                           result_mon.stack_count, result_mon.status});
        end else begin
          exp_o = expected_outcomes.pop_front();
          check_field("written_value", exp_o.value, result_mon.written_value);
          check_field("equal_flag", exp_o.equal, result_mon.equal_flag);
          check_field("stack_count", exp_o.depth, result_mon.stack_count);
          check_field("status", exp_o.status, result_mon.status);
        end
      end
      if (instr_mon.valid && instr_mon.ready) begin
        next_o = execute_instr(instr_mon.operation, instr_mon.dest_reg,
                               instr_mon.src_reg, instr_mon.use_immediate,
                               instr_mon.immediate);
        expected_outcomes.insert(expected_outcomes.size(), next_o);
      end
      pending_o <= expected_outcomes.size();
      fail_count_o <= fail_count;
    end
  end

endmodule

@@ dv/tb_byte_register_machine_execute.sv @@
`timescale 1ns / 1ps
// Top-level testbench: drives instructions and result stalls, and gives the verdict.
module tb_byte_register_machine_execute;
  import brme_pkg::*;

  localparam int unsigned RANDOM_ITEMS    = 1500;
  localparam logic [3:0]  OP_UNUSED_FIRST = 4'(OP_POP) + 4'd1;
  localparam logic [3:0]  OP_UNUSED_LAST  = '1;

  logic clk = 1'b0;
  logic rst_n;
  logic quiet = 1'b0;
  int   fail_count;
  int   pending;

  brme_in_if  instr_ch ();
  brme_out_if result_ch ();

  byte_register_machine_execute DUT (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .instr_i  (instr_ch),
    .result_o (result_ch)
  );

  brme_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .instr_mon    (instr_ch),
    .result_mon   (result_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk = ~clk;

  task automatic send_instr(input logic [3:0] opcode, input logic [2:0] d, input logic [2:0] s,
                            input logic use_imm, input logic [7:0] imm);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      instr_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_ch.valid         <= 1'b1;
    instr_ch.operation     <= opcode;
    instr_ch.dest_reg      <= d;
    instr_ch.src_reg       <= s;
    instr_ch.use_immediate <= use_imm;
    instr_ch.immediate     <= imm;
    do @(posedge clk); while (!instr_ch.ready);
  endtask

  task automatic drain_results();
    instr_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random_instr(input logic [3:0] opcode);
    logic [7:0] imm;
    imm = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 9));
    send_instr(opcode, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
               1'($urandom_range(0, 1)), imm);
  endtask

  initial begin
    int unsigned stall;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  initial begin
    int unsigned sent;
    int unsigned pick;
    int unsigned burst;
    rst_n                  <= 1'b0;
    instr_ch.valid         <= 1'b0;
    instr_ch.operation     <= OP_MOV;
    instr_ch.dest_reg      <= '0;
    instr_ch.src_reg       <= '0;
    instr_ch.use_immediate <= 1'b0;
    instr_ch.immediate     <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_instr(OP_POP,  3'd3, 3'd0, 1'b0, 8'h00);
    send_instr(OP_MOV,  3'd0, 3'd0, 1'b1, 8'hFF);
    send_instr(OP_MOV,  3'd1, 3'd0, 1'b1, 8'h01);
    send_instr(OP_MOV,  3'd2, 3'd0, 1'b0, 8'h5A);
    send_instr(OP_OR,   3'd3, 3'd0, 1'b1, 8'h00);
    send_instr(OP_XOR,  3'd3, 3'd2, 1'b0, 8'h00);
    send_instr(OP_AND,  3'd2, 3'd1, 1'b0, 8'h00);
    send_instr(OP_SHL,  3'd0, 3'd0, 1'b1, 8'h07);
    send_instr(OP_SHR,  3'd0, 3'd0, 1'b1, 8'h08);
    send_instr(OP_SHL,  3'd0, 3'd0, 1'b1, 8'hFF);
    send_instr(OP_MOV,  3'd4, 3'd0, 1'b1, 8'h09);
    send_instr(OP_SHR,  3'd2, 3'd4, 1'b0, 8'h00);
    send_instr(OP_MOV,  3'd5, 3'd0, 1'b1, 8'h03);
    send_instr(OP_SHL,  3'd1, 3'd5, 1'b0, 8'h00);
    send_instr(OP_ADD,  3'd0, 3'd0, 1'b0, 8'h00);
    send_instr(OP_SUB,  3'd3, 3'd1, 1'b0, 8'h00);
    send_instr(OP_MUL,  3'd3, 3'd3, 1'b0, 8'h00);
    send_instr(OP_DIV,  3'd3, 3'd2, 1'b0, 8'h00);
    send_instr(OP_DIV,  3'd3, 3'd5, 1'b0, 8'h00);
    send_instr(OP_CMP,  3'd2, 3'd0, 1'b0, 8'h00);
    send_instr(OP_CMP,  3'd3, 3'd5, 1'b0, 8'h00);
    send_instr(OP_PUSH, 3'd7, 3'd0, 1'b1, 8'hA5);
    send_instr(OP_PUSH, 3'd5, 3'd0, 1'b0, 8'h00);
    send_instr(OP_POP,  3'd6, 3'd0, 1'b0, 8'h00);
    send_instr(OP_UNUSED_FIRST, 3'd6, 3'd1, 1'b1, 8'h11);
    send_instr(OP_UNUSED_LAST,  3'd7, 3'd2, 1'b0, 8'h22);
    drain_results();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet = (sent % 300) >= 240;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        burst = $urandom_range(4, 20);
        repeat (burst) send_random_instr(OP_PUSH);
      end else if (pick < 14) begin
        burst = $urandom_range(4, 20);
        repeat (burst) send_random_instr(OP_POP);
      end else if (pick < 34) begin
        burst = 1;
        send_instr(OP_MOV, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 1'b1,
                   8'($urandom_range(0, 255)));
      end else begin
        burst = 1;
        send_random_instr(4'($urandom_range(0, 15)));
      end
      sent += burst;
    end
    quiet = 1'b0;
    drain_results();
    repeat (40) @(posedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ sim.f @@
src/brme_pkg.sv
src/brme_in_if.sv
src/brme_out_if.sv
src/brme_front.sv
src/brme_queue.sv
src/brme_div.sv
src/brme_back.sv
src/byte_register_machine_execute.sv
dv/brme_result_checker.sv
dv/tb_byte_register_machine_execute.sv
